// File: design/gmc_pkg.sv
// types, constants and microcode table shared by the graph coloring block
package gmc_pkg;

    localparam int ROW_W    = 16;
    localparam int VERTEX_W = 4;
    localparam int COLOR_W  = 5;
    localparam int NCOLORS  = 16;
    localparam int CFG_W    = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef struct packed {
        logic                op;
        logic [VERTEX_W-1:0] row_index;
        logic [ROW_W-1:0]    row_bits;
    } gmc_in_t;

    typedef struct packed {
        logic                found;
        logic [VERTEX_W-1:0] vertex;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } gmc_out_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_SOLVE = 1'b1
    } op_t;

    typedef enum logic {
        REG_VERTEX_COUNT = 1'b0,
        REG_COLOR_COUNT  = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_ROW,
        ST_ROWW,
        ST_CRD,
        ST_CACC,
        ST_PICK,
        ST_FIT,
        ST_NOFIT,
        ST_BACK,
        ST_BACK2,
        ST_OUT,
        ST_ORD,
        ST_OEMIT,
        ST_ONEXT,
        ST_FAIL
    } step_t;

    typedef enum logic [1:0] {D_HOLD, D_ZERO, D_INC, D_DEC} d_op_t;
    typedef enum logic [1:0] {UI_HOLD, UI_ZERO, UI_INC} u_op_t;
    typedef enum logic [1:0] {M_HOLD, M_CLR, M_ACC} m_op_t;
    typedef enum logic [1:0] {CS_HOLD, CS_ONE, CS_NEXT} cs_op_t;
    typedef enum logic {CR_U, CR_D} cr_sel_t;
    typedef enum logic [1:0] {OUT_NONE, OUT_COLOR, OUT_FAIL} out_op_t;

    typedef enum logic [3:0] {
        C_TRUE,
        C_SOLVE,
        C_U_EQ_D,
        C_U1_EQ_D,
        C_NOFIT,
        C_D1_EQ_N,
        C_D_ZERO,
        C_OUT_BUSY,
        C_U1_EQ_N
    } cond_t;

    typedef struct packed {
        logic    s_rdy;
        d_op_t   d_op;
        u_op_t   u_op;
        m_op_t   m_op;
        cs_op_t  cs_op;
        logic    row_ld;
        cr_sel_t cr_sel;
        logic    col_we;
        out_op_t out_op;
        cond_t   cond;
        step_t   t_true;
        step_t   t_false;
    } ctrl_t;

    typedef struct packed {
        logic solve_go;
        logic u_eq_d;
        logic u1_eq_d;
        logic nofit;
        logic d1_eq_n;
        logic d_zero;
        logic out_busy;
        logic u1_eq_n;
    } status_t;

    function automatic ctrl_t ucode(step_t s);
        ctrl_t w;
        w.s_rdy   = 1'b0;
        w.d_op    = D_HOLD;
        w.u_op    = UI_HOLD;
        w.m_op    = M_HOLD;
        w.cs_op   = CS_HOLD;
        w.row_ld  = 1'b0;
        w.cr_sel  = CR_U;
        w.col_we  = 1'b0;
        w.out_op  = OUT_NONE;
        w.cond    = C_TRUE;
        w.t_true  = ST_IDLE;
        w.t_false = ST_IDLE;
        unique case (s)
            ST_IDLE: begin
                w.s_rdy   = 1'b1;
                w.cond    = C_SOLVE;
                w.t_true  = ST_START;
                w.t_false = ST_IDLE;
            end
            ST_START: begin
                w.d_op   = D_ZERO;
                w.cs_op  = CS_ONE;
                w.t_true = ST_ROW;
            end
            ST_ROW: begin
                w.u_op   = UI_ZERO;
                w.m_op   = M_CLR;
                w.t_true = ST_ROWW;
            end
            ST_ROWW: begin
                w.row_ld  = 1'b1;
                w.cond    = C_U_EQ_D;
                w.t_true  = ST_PICK;
                w.t_false = ST_CRD;
            end
            ST_CRD: begin
                w.cr_sel = CR_U;
                w.t_true = ST_CACC;
            end
            ST_CACC: begin
                w.m_op    = M_ACC;
                w.u_op    = UI_INC;
                w.cond    = C_U1_EQ_D;
                w.t_true  = ST_PICK;
                w.t_false = ST_CRD;
            end
            ST_PICK: begin
                w.cond    = C_NOFIT;
                w.t_true  = ST_NOFIT;
                w.t_false = ST_FIT;
            end
            ST_FIT: begin
                w.col_we  = 1'b1;
                w.d_op    = D_INC;
                w.cs_op   = CS_ONE;
                w.cond    = C_D1_EQ_N;
                w.t_true  = ST_OUT;
                w.t_false = ST_ROW;
            end
            ST_NOFIT: begin
                w.d_op    = D_DEC;
                w.cond    = C_D_ZERO;
                w.t_true  = ST_FAIL;
                w.t_false = ST_BACK;
            end
            ST_BACK: begin
                w.cr_sel = CR_D;
                w.t_true = ST_BACK2;
            end
            ST_BACK2: begin
                w.cs_op  = CS_NEXT;
                w.t_true = ST_ROW;
            end
            ST_OUT: begin
                w.u_op   = UI_ZERO;
                w.t_true = ST_ORD;
            end
            ST_ORD: begin
                w.cr_sel = CR_U;
                w.t_true = ST_OEMIT;
            end
            ST_OEMIT: begin
                w.cr_sel  = CR_U;
                w.out_op  = OUT_COLOR;
                w.cond    = C_OUT_BUSY;
                w.t_true  = ST_OEMIT;
                w.t_false = ST_ONEXT;
            end
            ST_ONEXT: begin
                w.u_op    = UI_INC;
                w.cond    = C_U1_EQ_N;
                w.t_true  = ST_IDLE;
                w.t_false = ST_ORD;
            end
            ST_FAIL: begin
                w.out_op  = OUT_FAIL;
                w.cond    = C_OUT_BUSY;
                w.t_true  = ST_FAIL;
                w.t_false = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: design/graph_m_coloring_backtrack.sv
// top level of the graph m-coloring backtracking search block
//
//   channel  direction  handshake        payload
//   s_       in         s_valid/s_ready  gmc_in_t  (op, row_index, row_bits)
//   m_       out        m_valid/m_ready  gmc_out_t (found, vertex, color, last)
//   apb      in         psel/penable     vertex_count at 0x0, color_count at 0x4
//
// a load item is taken in the idle step
// a solve item walks the microcode: each vertex visit reads the color memory once per
// earlier vertex, a backtrack adds steps BACK and BACK2, each result ORD, OEMIT, ONEXT
// total solve time is data dependent and can grow exponentially with vertex count
// reset returns the sequencer to idle and the counts to 1 and 3; rows stay unwritten
// m_ready low holds the sequencer in its emit or fail step; s_ready is high only in idle
module graph_m_coloring_backtrack
    import gmc_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gmc_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output gmc_out_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int VLIMIT = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
    localparam int CW     = $clog2(VLIMIT + 1);
    localparam logic [CFG_W-1:0] VL_C = CFG_W'(VLIMIT);

    logic [CFG_W-1:0] vc_reg, vc_next;
    logic [CFG_W-1:0] cc_reg, cc_next;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;
    logic [CW-1:0]    n;
    ctrl_t            ctrl;
    status_t          status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb begin
        vc_next = vc_reg;
        cc_next = cc_reg;
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_VERTEX_COUNT: vc_next = pwdata[CFG_W-1:0];
                REG_COLOR_COUNT:  cc_next = pwdata[CFG_W-1:0];
            endcase
        end
        unique case (cfg_idx)
            REG_VERTEX_COUNT: prdata = APB_DW'(vc_reg);
            REG_COLOR_COUNT:  prdata = APB_DW'(cc_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= CFG_W'(1);
            cc_reg <= CFG_W'(3);
        end else begin
            vc_reg <= vc_next;
            cc_reg <= cc_next;
        end
    end

    // zero acts as one, large counts saturate
    always_comb begin
        if (vc_reg == '0) begin
            n = CW'(1);
        end else if (vc_reg > VL_C) begin
            n = CW'(VLIMIT);
        end else begin
            n = CW'(vc_reg);
        end
    end

    gmc_seq u_seq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .status (status),
        .ctrl   (ctrl)
    );

    gmc_dp #(
        .VLIMIT(VLIMIT)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (ctrl),
        .status (status),
        .n      (n),
        .cc     (cc_reg),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

// File: design/gmc_ram.sv
// generic one-write one-read memory with registered read data
module gmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/gmc_seq.sv
// microcode sequencer: step counter, control word lookup and conditional jumps
module gmc_seq
    import gmc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output ctrl_t   ctrl
);

    step_t upc_reg;
    step_t upc_next;
    ctrl_t word;
    logic  taken;

    always_comb begin
        word = ucode(upc_reg);
        unique case (word.cond)
            C_TRUE:     taken = 1'b1;
            C_SOLVE:    taken = status.solve_go;
            C_U_EQ_D:   taken = status.u_eq_d;
            C_U1_EQ_D:  taken = status.u1_eq_d;
            C_NOFIT:    taken = status.nofit;
            C_D1_EQ_N:  taken = status.d1_eq_n;
            C_D_ZERO:   taken = status.d_zero;
            C_OUT_BUSY: taken = status.out_busy;
            C_U1_EQ_N:  taken = status.u1_eq_n;
            default:    taken = 1'b1;
        endcase
        upc_next = taken ? word.t_true : word.t_false;
    end

    always_comb begin
        ctrl = ucode(upc_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ST_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: design/gmc_dp.sv
// datapath: row and color memories, search counters, color pick and output register
module gmc_dp
    import gmc_pkg::*;
#(
    parameter int VLIMIT = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ctrl_t                        ctrl,
    output status_t                      status,
    input  logic [$clog2(VLIMIT+1)-1:0]  n,
    input  logic [CFG_W-1:0]             cc,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  gmc_in_t                      s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output gmc_out_t                     m_data
);

    localparam int AW = $clog2(VLIMIT);
    localparam int CW = $clog2(VLIMIT + 1);
    localparam int MW = NCOLORS + 1;
    localparam logic [VERTEX_W:0] VL_V = (VERTEX_W + 1)'(VLIMIT);

    logic [CW-1:0]      d_reg, d_next;
    logic [CW-1:0]      u_reg, u_next;
    logic [COLOR_W-1:0] cs_reg, cs_next;
    logic [VLIMIT-1:0]  row_reg, row_next;
    logic [MW-1:0]      mask_reg, mask_next;
    gmc_out_t           out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               s_fire;
    logic               adj_we;
    logic [ROW_W-1:0]   adj_rdata;
    logic [COLOR_W-1:0] col_rdata;
    logic [AW-1:0]      col_raddr;
    logic [MW-1:0]      avail;
    logic [COLOR_W-1:0] pick;
    logic               out_busy;
    logic               out_load;

    assign s_ready = ctrl.s_rdy;
    assign s_fire  = s_valid & ctrl.s_rdy;
    assign adj_we  = s_fire && (s_data.op == OP_LOAD) && ({1'b0, s_data.row_index} < VL_V);

    gmc_ram #(
        .WIDTH(ROW_W),
        .DEPTH(VLIMIT)
    ) u_adj_ram (
        .aclk (aclk),
        .we   (adj_we),
        .waddr(AW'(s_data.row_index)),
        .wdata(s_data.row_bits),
        .raddr(d_reg[AW-1:0]),
        .rdata(adj_rdata)
    );

    assign col_raddr = (ctrl.cr_sel == CR_D) ? d_reg[AW-1:0] : u_reg[AW-1:0];

    gmc_ram #(
        .WIDTH(COLOR_W),
        .DEPTH(VLIMIT)
    ) u_col_ram (
        .aclk (aclk),
        .we   (ctrl.col_we),
        .waddr(d_reg[AW-1:0]),
        .wdata(pick),
        .raddr(col_raddr),
        .rdata(col_rdata)
    );

    // colors from cs up to cc (and at most NCOLORS) that no earlier neighbor holds
    always_comb begin
        for (int i = 0; i < MW; i++) begin
            avail[i] = (i != 0) && !mask_reg[i] && (COLOR_W'(i) >= cs_reg)
                       && (COLOR_W'(i) <= cc);
        end
        pick = '0;
        for (int i = MW - 1; i > 0; i--) begin
            if (avail[i]) begin
                pick = COLOR_W'(i);
            end
        end
    end

    assign out_busy = out_valid_reg & ~m_ready;
    assign out_load = (ctrl.out_op != OUT_NONE) && !out_busy;

    always_comb begin
        status.solve_go = s_fire && (s_data.op == OP_SOLVE);
        status.u_eq_d   = (u_reg == d_reg);
        status.u1_eq_d  = (CW'(u_reg + 1'b1) == d_reg);
        status.nofit    = (avail == '0);
        status.d1_eq_n  = (CW'(d_reg + 1'b1) == n);
        status.d_zero   = (d_reg == '0);
        status.out_busy = out_busy;
        status.u1_eq_n  = (CW'(u_reg + 1'b1) == n);
    end

    always_comb begin
        unique case (ctrl.d_op)
            D_HOLD: d_next = d_reg;
            D_ZERO: d_next = '0;
            D_INC:  d_next = d_reg + 1'b1;
            D_DEC:  d_next = d_reg - 1'b1;
        endcase

        unique case (ctrl.u_op)
            UI_ZERO: u_next = '0;
            UI_INC:  u_next = u_reg + 1'b1;
            default: u_next = u_reg;
        endcase

        unique case (ctrl.m_op)
            M_CLR: mask_next = '0;
            M_ACC: begin
                if (row_reg[u_reg[AW-1:0]]) begin
                    mask_next = mask_reg | (MW'(1) << col_rdata);
                end else begin
                    mask_next = mask_reg;
                end
            end
            default: mask_next = mask_reg;
        endcase

        unique case (ctrl.cs_op)
            CS_ONE:  cs_next = COLOR_W'(1);
            CS_NEXT: cs_next = col_rdata + 1'b1;
            default: cs_next = cs_reg;
        endcase

        row_next = ctrl.row_ld ? adj_rdata[VLIMIT-1:0] : row_reg;
    end

    always_comb begin
        out_next = out_reg;
        if (out_load) begin
            unique case (ctrl.out_op)
                OUT_COLOR: begin
                    out_next.found  = 1'b1;
                    out_next.vertex = VERTEX_W'(u_reg);
                    out_next.color  = col_rdata;
                    out_next.last   = status.u1_eq_n;
                end
                OUT_FAIL: begin
                    out_next.found  = 1'b0;
                    out_next.vertex = '0;
                    out_next.color  = '0;
                    out_next.last   = 1'b1;
                end
                default: out_next = out_reg;
            endcase
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg    <= d_next;
        u_reg    <= u_next;
        cs_reg   <= cs_next;
        row_reg  <= row_next;
        mask_reg <= mask_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_fit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.col_we |-> (pick != '0) && (pick <= cc) && (d_reg < n))
        else $error("color write outside the allowed range");

    a_scan_below_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.m_op == M_ACC) |-> (u_reg < d_reg))
        else $error("neighbor scan past the current vertex");

    a_fail_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (ctrl.out_op == OUT_FAIL))
        |=> (out_valid_reg && !out_reg.found && out_reg.last))
        else $error("failure item malformed");

endmodule
